/* rtl/tcg_pkg.sv */
// Shared types and constants for the text-mode character generator.
package tcg_pkg;

    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int COLOR_W     = 32;
    localparam int XPOS_W      = 9;
    localparam int FONT_DEPTH  = 2048;
    localparam int FONT_AW     = 11;
    localparam int PAL_MEM_AW  = 8;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_CELL    = 2'd0,
        KIND_FONT    = 2'd1,
        KIND_PALETTE = 2'd2,
        KIND_RENDER  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_FONT,
        ST_PAL
    } state_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic [XPOS_W-1:0]  pixel_x;
        logic [BYTE_W-1:0]  line;
        logic [COLOR_W-1:0] palette_word;
        logic [BYTE_W-1:0]  glyph_bits;
        logic [BYTE_W-1:0]  back_index;
        logic [BYTE_W-1:0]  fore_index;
        logic [BYTE_W-1:0]  char_code;
        logic [ADDR_W-1:0]  address;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] fore_index;
        logic [BYTE_W-1:0] back_index;
    } cell_t;

endpackage

/* rtl/text_mode_character_generator.sv */
// Text-mode character generator: top level with cell, font and palette memories.
// Write requests (cell, font row, palette entry) complete on acceptance. A render
// request passes through three chained memory reads (cell, then font row, then
// palette entry) followed by a load of the output register before the next
// request can be accepted. The output register
// holds a finished pixel until it is taken, so writes are accepted meanwhile; a
// further render waits in the palette step while the previous pixel is still
// unclaimed. Renders off the screen and palette indexes past the palette size
// return color zero. Memories have no reset; each entry must be written before
// a render reads it.
module text_mode_character_generator #(
    parameter int TEXT_ROWS       = 32,
    parameter int TEXT_COLUMNS    = 64,
    parameter int PIXELS_PER_LINE = 512,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // address, char_code, fore_index, back_index, glyph_bits, palette_word,
    // line, pixel_x, zero fill
    input  logic [tcg_pkg::IN_TDATA_W-1:0]   s_tdata,
    // kind
    input  logic [tcg_pkg::KIND_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_color
    output logic [tcg_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tcg_pkg::*;

    localparam int CELL_COUNT = TEXT_ROWS * TEXT_COLUMNS;
    localparam int CELL_DEPTH = (CELL_COUNT < 2048) ? CELL_COUNT : 2048;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int PAL_DEPTH  = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;

    cell_t              cell_mem [CELL_DEPTH];
    logic [BYTE_W-1:0]  font_mem [FONT_DEPTH];
    logic [COLOR_W-1:0] pal_mem  [2**PAL_MEM_AW];

    in_item_t item;
    kind_t    kind;
    logic     s_accept;
    logic     out_free;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] out_data_reg, out_data_next;

    cell_t              cell_rd_reg;
    logic [BYTE_W-1:0]  font_rd_reg;
    logic [COLOR_W-1:0] pal_rd_reg;
    logic               pal_zero_reg;
    logic [2:0]         grow_reg;
    logic [2:0]         xsel_reg;
    logic               off_reg;

    logic [4:0]  text_row;
    logic [5:0]  text_col;
    logic [12:0] cell_idx;
    logic        off_screen;
    logic [2:0]  bit_sel;
    logic        glyph_on;
    logic [BYTE_W-1:0] pal_idx;

    assign item     = in_item_t'(s_tdata);
    assign kind     = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign text_row   = item.line[7:3];
    assign text_col   = item.pixel_x[8:3];
    assign cell_idx   = 13'(text_row) * 13'(TEXT_COLUMNS) + 13'(text_col);
    assign off_screen = (7'(text_row) >= 7'(TEXT_ROWS)) ||
                        (7'(text_col) >= 7'(TEXT_COLUMNS)) ||
                        (10'(item.pixel_x) >= 10'(PIXELS_PER_LINE));

    assign bit_sel  = 3'd7 - xsel_reg;
    assign glyph_on = font_rd_reg[bit_sel];
    assign pal_idx  = glyph_on ? cell_rd_reg.fore_index : cell_rd_reg.back_index;

    always_ff @(posedge aclk) begin
        if (s_accept && kind == KIND_CELL && 13'(item.address) < 13'(CELL_DEPTH)) begin
            cell_mem[item.address[CELL_AW-1:0]] <= '{char_code:  item.char_code,
                                                     fore_index: item.fore_index,
                                                     back_index: item.back_index};
        end
        if (state_reg == ST_IDLE) begin
            cell_rd_reg <= cell_mem[cell_idx[CELL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && kind == KIND_FONT) begin
            font_mem[item.address] <= item.glyph_bits;
        end
        if (state_reg == ST_CELL) begin
            font_rd_reg <= font_mem[{cell_rd_reg.char_code, grow_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && kind == KIND_PALETTE && 12'(item.address) < 12'(PAL_DEPTH)) begin
            pal_mem[item.address[PAL_MEM_AW-1:0]] <= item.palette_word;
        end
        if (state_reg == ST_FONT) begin
            pal_rd_reg   <= pal_mem[pal_idx];
            pal_zero_reg <= off_reg || (9'(pal_idx) >= 9'(PAL_DEPTH));
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            grow_reg <= item.line[2:0];
            xsel_reg <= item.pixel_x[2:0];
            off_reg  <= off_screen;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && kind == KIND_RENDER) begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                state_next = ST_FONT;
            end
            ST_FONT: begin
                state_next = ST_PAL;
            end
            ST_PAL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = pal_zero_reg ? '0 : pal_rd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tcg_checker.sv */
// Port-level assertions for the text-mode character generator, bound to the top level.
module tcg_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [tcg_pkg::KIND_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tcg_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tcg_pkg::*;

    logic render_acc;
    logic write_acc;

    assign render_acc = s_tvalid && s_tready && s_tuser == KIND_RENDER;
    assign write_acc  = s_tvalid && s_tready && s_tuser != KIND_RENDER;

    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        render_acc |=> !s_tready)
        else $error("request port stayed ready after a render request");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        write_acc |=> !$rose(m_tvalid))
        else $error("result appeared right after a write request");

    a_result_after_render: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a render in progress");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind text_mode_character_generator tcg_checker u_tcg_checker (.*);
